>>> src/csc_pkg.sv
// ============================================================================
// csc_pkg - shared types and constants of the compass search step controller
// Field widths, register map, reset values and the control/status bundles
// between the sequencer and the datapath.
// ============================================================================
package csc_pkg;

    localparam int MAX_PARAMS = 12;

    localparam int NUM_PARAMS_W  = 4;
    localparam int STEP_LEVELS_W = 6;
    localparam int MAX_ITER_W    = 16;
    localparam int STEP_W        = 31;
    localparam int THR_W         = 47;
    localparam int COST_W        = 48;
    localparam int PARAM_W       = 32;
    localparam int INDEX_W       = 4;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 120;

    typedef enum logic [2:0] {
        REG_NUM_PARAMS    = 3'd0,
        REG_STEP_LEVELS   = 3'd1,
        REG_MAX_ITER      = 3'd2,
        REG_INIT_STEP     = 3'd3,
        REG_IMPROVE_THR   = 3'd4
    } reg_idx_t;

    localparam logic [NUM_PARAMS_W-1:0]  NUM_PARAMS_RST  = 4'd6;
    localparam logic [STEP_LEVELS_W-1:0] STEP_LEVELS_RST = 6'd1;
    localparam logic [MAX_ITER_W-1:0]    MAX_ITER_RST    = 16'd500;
    localparam logic [STEP_W-1:0]        INIT_STEP_RST   = 31'd65536;
    localparam logic [THR_W-1:0]         IMPROVE_THR_RST = 47'd17;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic [NUM_PARAMS_W-1:0]  param_count;
        logic [STEP_LEVELS_W-1:0] step_levels;
        logic [MAX_ITER_W-1:0]    max_iterations;
        logic [STEP_W-1:0]        init_step;
        logic [THR_W-1:0]         improve_threshold;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic latch;
        logic classify;
        logic decide;
        logic apply;
        logic step_end;
        logic done_upd;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic plus_pair;
        logic iter_end;
        logic out_free;
        logic emit_last;
    } stat_t;

endpackage

>>> src/csc_regs.sv
// ============================================================================
// csc_regs - configuration register file
// APB-style write/read port holding the search settings.
// ============================================================================
module csc_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [csc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [csc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [csc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output csc_pkg::cfg_t                     cfg
);

    csc_pkg::cfg_t     cfg_reg;
    csc_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = csc_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.param_count       <= csc_pkg::NUM_PARAMS_RST;
            cfg_reg.step_levels       <= csc_pkg::STEP_LEVELS_RST;
            cfg_reg.max_iterations    <= csc_pkg::MAX_ITER_RST;
            cfg_reg.init_step         <= csc_pkg::INIT_STEP_RST;
            cfg_reg.improve_threshold <= csc_pkg::IMPROVE_THR_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                csc_pkg::REG_NUM_PARAMS:  cfg_reg.param_count       <= pwdata[3:0];
                csc_pkg::REG_STEP_LEVELS: cfg_reg.step_levels       <= pwdata[5:0];
                csc_pkg::REG_MAX_ITER:    cfg_reg.max_iterations    <= pwdata[15:0];
                csc_pkg::REG_INIT_STEP:   cfg_reg.init_step         <= pwdata[30:0];
                csc_pkg::REG_IMPROVE_THR: cfg_reg.improve_threshold <= pwdata[46:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            csc_pkg::REG_NUM_PARAMS:  prdata = 64'(cfg_reg.param_count);
            csc_pkg::REG_STEP_LEVELS: prdata = 64'(cfg_reg.step_levels);
            csc_pkg::REG_MAX_ITER:    prdata = 64'(cfg_reg.max_iterations);
            csc_pkg::REG_INIT_STEP:   prdata = 64'(cfg_reg.init_step);
            csc_pkg::REG_IMPROVE_THR: prdata = 64'(cfg_reg.improve_threshold);
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> src/csc_datapath.sv
// ============================================================================
// csc_datapath - parameter/step stores, cost registers and counters
// Executes the sequencer's commands and drives the output word register.
// ============================================================================
module csc_datapath #(
    parameter int MAX_PARAMS = csc_pkg::MAX_PARAMS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  csc_pkg::cfg_t                     cfg,
    input  csc_pkg::cmd_t                     cmd,
    output csc_pkg::stat_t                    stat,
    input  logic signed [csc_pkg::COST_W-1:0] s_cost,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [csc_pkg::INDEX_W-1:0]       m_index,
    output logic signed [csc_pkg::PARAM_W-1:0] m_value,
    output logic [csc_pkg::STEP_W-1:0]        m_step,
    output logic signed [csc_pkg::COST_W-1:0] m_centre,
    output logic                              m_finished,
    output logic                              m_last
);

    localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CNT_W = $clog2(2 * MAX_PARAMS + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam int IW    = csc_pkg::INDEX_W;
    localparam int CW    = csc_pkg::COST_W;
    localparam int DW    = csc_pkg::COST_W + 1;
    localparam int SW    = csc_pkg::PARAM_W + 2;

    logic signed [csc_pkg::PARAM_W-1:0] param_reg [MAX_PARAMS];
    logic [csc_pkg::STEP_W-1:0]         step_reg  [MAX_PARAMS];

    logic signed [CW-1:0] centre_reg;
    logic signed [CW-1:0] minus_reg;
    logic signed [CW-1:0] cost_reg;
    logic signed [DW-1:0] dneg_reg;
    logic signed [DW-1:0] dpos_reg;
    logic signed [DW-1:0] gain_reg;
    logic                 use_neg_reg;

    logic [CNT_W-1:0]                  cnt_reg;
    logic                              moved_reg;
    logic [csc_pkg::STEP_LEVELS_W-1:0] level_reg;
    logic [csc_pkg::MAX_ITER_W-1:0]    iter_reg;
    logic                              done_reg;
    logic [IDX_W-1:0]                  emit_idx_reg;

    logic                               m_valid_reg;
    logic [IW-1:0]                      m_index_reg;
    logic signed [csc_pkg::PARAM_W-1:0] m_value_reg;
    logic [csc_pkg::STEP_W-1:0]         m_step_reg;
    logic signed [CW-1:0]               m_centre_reg;
    logic                               m_finished_reg;
    logic                               m_last_reg;

    logic [csc_pkg::NUM_PARAMS_W-1:0] n_act;
    logic [CMP_W-1:0]                 n_ext;
    logic [CMP_W-1:0]                 two_n;
    logic [CMP_W-1:0]                 cnt_ext;
    logic [CMP_W-1:0]                 p_ext;
    logic [IDX_W-1:0]                 p_idx;
    logic                             p_ok;
    logic                             emit_last;
    logic                             out_free;
    logic                             iter_end;
    logic                             gain_hit;
    logic                             search_over;
    logic [IDX_W-1:0]                 rd_idx;
    logic signed [csc_pkg::PARAM_W-1:0] rd_param;
    logic [csc_pkg::STEP_W-1:0]       rd_step;
    logic signed [SW-1:0]             sum;
    logic signed [csc_pkg::PARAM_W-1:0] sat;

    always_comb begin
        if (cfg.param_count == '0) begin
            n_act = 4'd1;
        end else if (int'(cfg.param_count) > MAX_PARAMS) begin
            n_act = 4'(MAX_PARAMS);
        end else begin
            n_act = cfg.param_count;
        end
    end

    assign n_ext     = CMP_W'(n_act);
    assign two_n     = n_ext << 1;
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign p_ext     = (cnt_ext - CMP_W'(1)) >> 1;
    assign p_idx     = IDX_W'(p_ext);
    assign p_ok      = (cnt_ext != '0) && (p_ext < n_ext);
    assign iter_end  = cnt_ext >= two_n;
    assign emit_last = (CMP_W'(emit_idx_reg) + CMP_W'(1)) == n_ext;
    assign out_free  = !m_valid_reg || m_ready;
    assign gain_hit  = gain_reg > $signed({2'b00, cfg.improve_threshold});
    assign search_over = (level_reg >= cfg.step_levels) || (iter_reg >= cfg.max_iterations);

    assign stat.done      = done_reg;
    assign stat.plus_pair = p_ok && !cnt_reg[0];
    assign stat.iter_end  = iter_end;
    assign stat.out_free  = out_free;
    assign stat.emit_last = emit_last;

    assign rd_idx   = cmd.emit_load ? emit_idx_reg : p_idx;
    assign rd_param = param_reg[rd_idx];
    assign rd_step  = step_reg[rd_idx];

    always_comb begin
        if (use_neg_reg) begin
            sum = SW'(rd_param) - $signed(SW'(rd_step));
        end else begin
            sum = SW'(rd_param) + $signed(SW'(rd_step));
        end
        if (!sum[SW-1] && sum[SW-2:SW-3] != 2'b00) begin
            sat = 32'sh7FFF_FFFF;
        end else if (sum[SW-1] && sum[SW-2:SW-3] != 2'b11) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = sum[csc_pkg::PARAM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
                param_reg[i] <= '0;
                step_reg[i]  <= cfg.init_step;
            end
            centre_reg <= '0;
            minus_reg  <= '0;
        end
        if (cmd.latch) begin
            cost_reg <= s_cost;
        end
        if (cmd.classify) begin
            if (cnt_reg == '0) begin
                centre_reg <= cost_reg;
            end else if (p_ok && cnt_reg[0]) begin
                minus_reg <= cost_reg;
            end
            dneg_reg <= DW'(centre_reg) - DW'(minus_reg);
            dpos_reg <= DW'(centre_reg) - DW'(cost_reg);
        end
        if (cmd.decide) begin
            use_neg_reg <= dneg_reg > dpos_reg;
            gain_reg    <= (dneg_reg > dpos_reg) ? dneg_reg : dpos_reg;
        end
        if (cmd.apply && gain_hit) begin
            param_reg[p_idx] <= sat;
        end
        if (cmd.step_end && iter_end && !moved_reg) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
                step_reg[i] <= step_reg[i] >> 1;
            end
        end
        if (cmd.emit_load) begin
            m_index_reg    <= IW'(emit_idx_reg);
            m_value_reg    <= rd_param;
            m_step_reg     <= rd_step;
            m_centre_reg   <= centre_reg;
            m_finished_reg <= done_reg;
            m_last_reg     <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            moved_reg    <= 1'b0;
            level_reg    <= '0;
            iter_reg     <= '0;
            done_reg     <= 1'b1;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.start) begin
                cnt_reg   <= '0;
                moved_reg <= 1'b0;
                level_reg <= '0;
                iter_reg  <= '0;
            end
            if (cmd.apply && gain_hit) begin
                moved_reg <= 1'b1;
            end
            if (cmd.step_end) begin
                if (!iter_end) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end else begin
                    iter_reg <= iter_reg + 16'd1;
                    if (!moved_reg) begin
                        level_reg <= level_reg + 6'd1;
                    end
                    cnt_reg   <= '0;
                    moved_reg <= 1'b0;
                end
            end
            if (cmd.done_upd) begin
                done_reg     <= search_over;
                emit_idx_reg <= '0;
            end
            if (cmd.emit_load) begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_index    = m_index_reg;
    assign m_value    = m_value_reg;
    assign m_step     = m_step_reg;
    assign m_centre   = m_centre_reg;
    assign m_finished = m_finished_reg;
    assign m_last     = m_last_reg;

endmodule

>>> src/csc_ctrl.sv
// ============================================================================
// csc_ctrl - sequencer of the compass search step controller
// Accepts one input word at a time and steps the datapath through
// classify, decide, apply, counter update and vector output.
// ============================================================================
module csc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_opcode,
    output logic           s_ready,
    input  csc_pkg::stat_t stat,
    output csc_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_CLASSIFY = 7'b0000010,
        S_DECIDE   = 7'b0000100,
        S_APPLY    = 7'b0001000,
        S_STEP_END = 7'b0010000,
        S_DONE_UPD = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == csc_pkg::OP_START) begin
                        cmd.start  = 1'b1;
                        state_next = S_DONE_UPD;
                    end else if (!stat.done) begin
                        cmd.latch  = 1'b1;
                        state_next = S_CLASSIFY;
                    end
                end
            end
            S_CLASSIFY: begin
                cmd.classify = 1'b1;
                state_next   = stat.plus_pair ? S_DECIDE : S_STEP_END;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_STEP_END;
            end
            S_STEP_END: begin
                cmd.step_end = 1'b1;
                state_next   = stat.iter_end ? S_DONE_UPD : S_IDLE;
            end
            S_DONE_UPD: begin
                cmd.done_upd = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (stat.emit_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/compass_search_step_controller.sv
// ============================================================================
// compass_search_step_controller - compass search (coordinate hill-climb) step
// controller
// Takes start and cost-sample words, updates the parameter and step vectors and
// streams the vector out at each start and at the end of each iteration.
// ============================================================================
// A start word passes the finish check before the output vector begins; a sample
// word runs through the classify (difference) and counter update states (centre or
// minus sample) or through classify, select, saturating update and counter update
// (plus sample) in the sequencer before the next word is taken. The sample that
// closes an iteration adds the finish check and then streams n words, one per cycle
// while m_tready is high, from the parameter and step registers over a single read
// port. Samples arriving after the search is finished are taken and dropped.
// ============================================================================
module compass_search_step_controller #(
    parameter int MAX_PARAMS = csc_pkg::MAX_PARAMS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [csc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [csc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [csc_pkg::S_DATA_W-1:0]    s_tdata,   // [47:0] cost_value
    input  logic [0:0]                      s_tuser,   // [0] opcode
    // output words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [csc_pkg::M_DATA_W-1:0]    m_tdata,   // [3:0] param_index,
                                                       // [35:4] param_value,
                                                       // [66:36] step_size,
                                                       // [114:67] centre_cost
    output logic [0:0]                      m_tuser,   // [0] finished
    output logic                            m_tlast
);

    csc_pkg::cfg_t  cfg;
    csc_pkg::cmd_t  cmd;
    csc_pkg::stat_t stat;

    logic [csc_pkg::INDEX_W-1:0]         m_index;
    logic signed [csc_pkg::PARAM_W-1:0]  m_value;
    logic [csc_pkg::STEP_W-1:0]          m_step;
    logic signed [csc_pkg::COST_W-1:0]   m_centre;
    logic                                m_finished;

    csc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_opcode (s_tuser[0]),
        .s_ready  (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csc_datapath #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .s_cost     ($signed(s_tdata[csc_pkg::COST_W-1:0])),
        .m_ready    (m_tready),
        .m_valid    (m_tvalid),
        .m_index    (m_index),
        .m_value    (m_value),
        .m_step     (m_step),
        .m_centre   (m_centre),
        .m_finished (m_finished),
        .m_last     (m_tlast)
    );

    assign m_tdata    = {5'b00000, m_centre, m_step, m_value, m_index};
    assign m_tuser[0] = m_finished;

endmodule
